// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/wsbs_pkg.sv =====
// ----------------------------------------------------------------------------
// wsbs_pkg
// shared types and constants of the wildcard byte signature search
// ----------------------------------------------------------------------------
`default_nettype none

package wsbs_pkg;

  // signature storage is always sixteen bytes wide
  localparam int SIG_BYTES    = 16;
  localparam int SIG_BITS     = SIG_BYTES * 8;
  localparam int SIG_IDX_W    = 4;
  localparam int LEN_W        = 5;

  // defaults for the top level parameters
  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_OFFSET_BITS = 32;

  // stream and configuration widths
  localparam int OUT_OFFSET_W = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd3;

  // reset values
  localparam logic [SIG_BYTES-1:0] CARE_RESET = '1;
  localparam logic [LEN_W-1:0]     LEN_RESET  = 5'd1;

  // per-cell status toward the match logic
  typedef struct packed {
    logic hit;     // this position agrees with the signature, is masked out or is unused
    logic filled;  // this position holds a byte of the current buffer
  } cell_status_t;

endpackage

`default_nettype wire

// ===== sv/wildcard_byte_signature_search_core.sv =====
// ----------------------------------------------------------------------------
// wildcard_byte_signature_search_core
// first-match search of a masked byte signature over a streamed buffer
// ----------------------------------------------------------------------------
// output: a result enters the output register as the final byte of its window
//   is accepted
// throughput: one byte per cycle unless a held result stalls the input; the window
//   shifts through the cell row and every position compares in the cycle the byte enters
// reset: clears the window fill flags, byte count, match flag and output
//   valid; registers return to an all-care, length-one zero signature
`default_nettype none

module wildcard_byte_signature_search_core #(
  parameter int MAX_PATTERN = wsbs_pkg::DEF_MAX_PATTERN,
  parameter int OFFSET_BITS = wsbs_pkg::DEF_OFFSET_BITS
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // input stream
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  input  wire  [7:0]                            s_tdata,   // buffer_byte[7:0]
  input  wire                                   s_tlast,   // last_byte
  // result stream
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  output logic [wsbs_pkg::OUT_OFFSET_W-1:0]     m_tdata,   // match_offset[31:0]
  output logic                                  m_tuser,   // found
  // configuration writes
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [wsbs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [wsbs_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import wsbs_pkg::*;

  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CFG_DATA_W-1:0]  pattern_low;
  logic [CFG_DATA_W-1:0]  pattern_high;
  logic [SIG_BYTES-1:0]   care_mask;
  logic [LEN_W-1:0]       pattern_length;

  logic [LEN_W-1:0]       len_eff;
  logic [IDX_W-1:0]       len_idx;
  logic [SIG_BITS-1:0]    sig;

  logic                   accept;
  logic [7:0]             byte_chain  [MAX_PATTERN+1];
  logic                   valid_chain [MAX_PATTERN+1];
  cell_status_t           status      [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hits;
  logic [MAX_PATTERN-1:0] filled;

  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic [OFFSET_BITS-1:0] offset_full;
  logic                   match_reported;
  logic                   match_now;
  logic                   emit;

  // configuration register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= CARE_RESET;
      pattern_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_CARE_MASK:    care_mask      <= cfg_data[SIG_BYTES-1:0];
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  // length clamped to the range one to the cell count
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length;
    end
    len_idx = IDX_W'(len_eff - LEN_W'(1));
    sig     = {pattern_high, pattern_low};
  end

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // cell row, newest byte enters at position zero
  assign byte_chain[0]  = s_tdata;
  assign valid_chain[0] = 1'b1;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wsbs_cell #(
      .POS (k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept),
      .clear     (s_tlast),
      .byte_in   (byte_chain[k]),
      .valid_in  (valid_chain[k]),
      .sig       (sig),
      .care      (care_mask),
      .len       (len_eff),
      .byte_out  (byte_chain[k+1]),
      .valid_out (valid_chain[k+1]),
      .status    (status[k])
    );
    assign hits[k]   = status[k].hit;
    assign filled[k] = status[k].filled;
  end

  // match decision and offset
  always_comb begin
    bytes_seen_next = (bytes_seen == '1) ? bytes_seen
                                         : bytes_seen + OFFSET_BITS'(1);
    offset_full     = bytes_seen_next - OFFSET_BITS'(len_eff);
    match_now       = !match_reported && filled[len_idx] && (&hits);
    emit            = match_now || (s_tlast && !match_reported);
  end

  // buffer tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen     <= '0;
        match_reported <= 1'b0;
      end else begin
        bytes_seen     <= bytes_seen_next;
        match_reported <= match_reported || match_now;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tuser <= match_now;
      m_tdata <= match_now ? OUT_OFFSET_W'(offset_full) : '0;
    end
  end

`include "assert_macros.svh"

  // a buffer end always rearms the match flag
  `ASSERT_NEXT(a_rearm, clk, rst, accept && s_tlast, !match_reported)
  // once reported, nothing new enters the output register
  `ASSERT_NEXT(a_single, clk, rst, accept && match_reported && m_tready, !m_tvalid)
  // a not-found result carries a zero offset
  `ASSERT_IMPL(a_nf_zero, clk, rst, m_tvalid && !m_tuser, m_tdata == '0)
  // the byte count never drops inside a buffer
  `ASSERT_NEXT(a_count, clk, rst, accept && !s_tlast, bytes_seen >= $past(bytes_seen))

endmodule

`default_nettype wire

// ===== sv/wsbs_cell.sv =====
// ----------------------------------------------------------------------------
// wsbs_cell
// one window position: holds a byte and compares it with its signature byte
// ----------------------------------------------------------------------------
`default_nettype none

module wsbs_cell #(
  parameter int POS = 0
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   shift,
  input  wire                                   clear,
  input  wire  [7:0]                            byte_in,
  input  wire                                   valid_in,
  input  wire  [wsbs_pkg::SIG_BITS-1:0]         sig,
  input  wire  [wsbs_pkg::SIG_BYTES-1:0]        care,
  input  wire  [wsbs_pkg::LEN_W-1:0]            len,
  output logic [7:0]                            byte_out,
  output logic                                  valid_out,
  output wsbs_pkg::cell_status_t                status
);
  import wsbs_pkg::*;

  logic                 used;
  logic [LEN_W-1:0]     sel_full;
  logic [SIG_IDX_W-1:0] sel;
  logic [7:0]           sig_byte;

  // signature byte that lines up with this position for the current length
  always_comb begin
    used     = (LEN_W'(POS) < len);
    sel_full = len - LEN_W'(1) - LEN_W'(POS);
    sel      = sel_full[SIG_IDX_W-1:0];
    sig_byte = sig[{sel, 3'b000} +: 8];
  end

  // compare against the byte that enters this position
  always_comb begin
    status.hit    = !used || !care[sel] || (byte_in == sig_byte);
    status.filled = valid_in;
  end

  // window byte, no reset needed
  always_ff @(posedge clk) begin
    if (shift) begin
      byte_out <= byte_in;
    end
  end

  // fill flag, cleared at buffer end
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (shift) begin
      valid_out <= clear ? 1'b0 : valid_in;
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the wildcard byte signature search core
// ----------------------------------------------------------------------------
// buffers of bytes stream in on the slave side while a scoreboard model
// tracks the sliding window, byte count and found flag. The model predicts
// the first-match offset or the not-found result of each buffer. Results on
// the master side are checked in order against the predictions. Signature,
// care mask and length are rewritten between phases while the core is idle.
// Phases run with sender and receiver stalls and with no stalls.

module tb_top;
  import wsbs_pkg::*;

  // one byte request and one search result
  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } byte_req_t;

  typedef struct packed {
    logic        found;
    logic [31:0] offset;
  } search_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_OFFSET_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // scoreboard copy of the registers and the scan state
  logic [SIG_BITS-1:0]   sig_bytes = '0;
  logic [15:0]           care_bits = '1;
  logic [4:0]            len_reg = 5'd1;
  logic [7:0]            window_q [16];
  logic [31:0]           seen_count = '0;
  bit                    already_found = 1'b0;

  byte_req_t             buffer_bytes_q [$];
  search_result_t        pending_results [$];
  int                    mismatch_count = 0;
  int unsigned           send_idle_pct = 6;
  int unsigned           recv_idle_pct = 85;
  bit                    byte_taken = 1'b0;

  wildcard_byte_signature_search_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // length in use, clamped to 1..16
  function automatic int unsigned active_len();
    if (len_reg == 5'd0) return 1;
    if (len_reg > 5'd16) return 16;
    return 32'(len_reg);
  endfunction

  // shift one byte into the window and work out any result it causes
  function automatic void scan_byte(input logic [7:0] b, input logic is_last);
    int unsigned n;
    int i;
    bit hit;
    search_result_t res;
    n = active_len();
    for (i = 15; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = b;
    if (seen_count != '1) seen_count++;
    if (!already_found && seen_count >= n) begin
      hit = 1'b1;
      for (i = 0; i < n; i++)
        if (care_bits[i] && window_q[n-1-i] != sig_bytes[i*8 +: 8]) hit = 1'b0;
      if (hit) begin
        res.found = 1'b1;
        res.offset = seen_count - n;
        pending_results.push_back(res);
        already_found = 1'b1;
      end
    end
    if (is_last) begin
      if (!already_found) begin
        res.found = 1'b0;
        res.offset = '0;
        pending_results.push_back(res);
      end
      for (i = 0; i < 16; i++) window_q[i] = '0;
      seen_count = '0;
      already_found = 1'b0;
    end
  endfunction

  // byte driver, fed from the request queue
  always @(negedge clk) begin : drive_bytes
    byte_req_t next_req;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || byte_taken) begin
      if (buffer_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = buffer_bytes_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_req.value;
        s_tlast  <= next_req.is_last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver backpressure
  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  // accepted bytes feed the model, accepted results are checked
  always @(posedge clk) begin : watch_streams
    search_result_t want;
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) scan_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got found %0b offset %0d",
                   $time, m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.found) begin
            $display("%0t: found flag, expected %0b, got %0b", $time, want.found, m_tuser);
            mismatch_count++;
          end
          if (m_tdata !== want.offset) begin
            $display("%0t: match offset, expected %0d, got %0d",
                     $time, want.offset, m_tdata);
            mismatch_count++;
          end
        end
      end
    end
  end

  // one register write request, mirrored into the model once taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:  sig_bytes[63:0] = value;
      REG_PATTERN_HIGH: sig_bytes[127:64] = value;
      REG_CARE_MASK:    care_bits = value[15:0];
      REG_PATTERN_LEN:  len_reg = value[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic is_last);
    byte_req_t req;
    req.value = b;
    req.is_last = is_last;
    buffer_bytes_q.push_back(req);
  endtask

  // hold off until every byte is in and every result is out
  task automatic drain();
    @(posedge clk);
    while (buffer_bytes_q.size() != 0 || s_tvalid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // new signature settings for a random phase, extremes forced early on
  task automatic pick_settings(input int phase);
    logic [63:0] word;
    logic [15:0] care;
    logic [4:0] len;
    if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_PATTERN_LOW, rand_word());
    if (phase == 0 || $urandom_range(3) != 0) write_reg(REG_PATTERN_HIGH, rand_word());
    case ($urandom_range(5))
      0: care = '0;
      1: care = '1;
      default: care = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(9))
      0: len = 5'd0;
      1: len = 5'd16;
      2: len = 5'($urandom_range(31, 17));
      default: len = 5'($urandom_range(8, 1));
    endcase
    if (phase == 0) len = 5'd16;
    if (phase == 1) begin
      len = 5'd31;
      care = '0;
    end
    if (phase == 2) len = 5'd0;
    // upper bits of the write data carry junk half of the time
    word = {$urandom, $urandom};
    if ($urandom_range(1)) word[63:16] = '0;
    word[15:0] = care;
    write_reg(REG_CARE_MASK, word);
    word = {$urandom, $urandom};
    if ($urandom_range(1)) word[63:5] = '0;
    word[4:0] = len;
    write_reg(REG_PATTERN_LEN, word);
  endtask

  // one buffer of random bytes, mostly with the signature planted in it
  task automatic queue_buffer(output int count);
    logic [7:0] frame [$];
    int n, p, i, copies;
    bit from_sig;
    n = active_len();
    count = ($urandom_range(11) == 0) ? $urandom_range(300, 1) : $urandom_range(3 * n + 8, 1);
    from_sig = ($urandom_range(2) == 0);
    for (i = 0; i < count; i++)
      frame.push_back(from_sig ? sig_bytes[$urandom_range(n - 1) * 8 +: 8]
                               : 8'($urandom_range(255)));
    copies = ($urandom_range(9) < 6) ? 1 : (($urandom_range(3) == 0) ? 2 : 0);
    repeat (copies) begin
      if (count >= n) begin
        p = $urandom_range(count - n);
        for (i = 0; i < n; i++)
          if (care_bits[i]) frame[p+i] = sig_bytes[i*8 +: 8];
      end
    end
    for (i = 0; i < count; i++) push_byte(frame[i], i == count - 1);
  endtask

  // stimulus sequence
  initial begin
    int phase;
    int random_bytes;
    int phase_bytes;
    int nb;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero byte, length one, full care; match on final byte
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    drain();

    // four byte signature with a wildcard, unused bytes and care bits set
    write_reg(REG_PATTERN_LOW, 64'h0123_4567_EF3F_ADDE);
    write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_CARE_MASK, 64'h0000_0000_0000_FFFB);
    write_reg(REG_PATTERN_LEN, 64'd4);
    // buffer shorter than the signature
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b1);
    // match, then bytes after it and a silent rearm
    push_byte(8'h00, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hEF, 1'b0);
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hEF, 1'b1);
    // buffer exactly the signature, the wildcard byte being a literal '?'
    push_byte(8'hDE, 1'b0);
    push_byte(8'hAD, 1'b0);
    push_byte(8'h3F, 1'b0);
    push_byte(8'hEF, 1'b1);
    drain();

    // length zero behaves as one
    write_reg(REG_PATTERN_LOW, 64'h0000_0000_0000_00FF);
    write_reg(REG_PATTERN_LEN, 64'd0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b1);
    drain();

    // random phases, stall pattern chosen by progress
    phase = 0;
    random_bytes = 0;
    while (random_bytes < 1200) begin
      if (random_bytes < 400) begin
        send_idle_pct = 6;
        recv_idle_pct = 85;
      end else if (random_bytes < 800) begin
        send_idle_pct = 85;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick_settings(phase);
      phase_bytes = 0;
      while (phase_bytes < 100) begin
        queue_buffer(nb);
        phase_bytes += nb;
      end
      random_bytes += phase_bytes;
      drain();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("wildcard_byte_signature_search_core: match");
    end else begin
      $display("wildcard_byte_signature_search_core: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("wildcard_byte_signature_search_core: mismatch");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/wsbs_pkg.sv
sv/wsbs_cell.sv
sv/wildcard_byte_signature_search_core.sv
verif/tb_top.sv
